/* src/assert_macros.svh */
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequence holds in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/dktq_pkg.sv */
// ----------------------------------------------------------------------------
// dktq_pkg
// Types, codes and constants shared by the dual-key top-k queue.
// ----------------------------------------------------------------------------
package dktq_pkg;

  localparam int DefCapacity = 64;
  localparam int IdW         = 16;
  localparam int KeyW        = 32;
  localparam int KindW       = 3;
  localparam int FillW       = 7;

  localparam logic [KindW-1:0] KIND_PUSH     = 3'd0;
  localparam logic [KindW-1:0] KIND_PUSH_BET = 3'd1;
  localparam logic [KindW-1:0] KIND_POP_G    = 3'd2;
  localparam logic [KindW-1:0] KIND_POP_L    = 3'd3;
  localparam logic [KindW-1:0] KIND_CLEAR    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIX,
    ST_OUT
  } dktq_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request
    logic exec;     // evict/insert/pop first half
    logic fix;      // link update or partner delete
  } dktq_cmd_t;

endpackage

/* src/dktq_if.sv */
// ----------------------------------------------------------------------------
// dktq_in_if / dktq_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface dktq_in_if;
  import dktq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [KindW-1:0]        kind;
  logic [IdW-1:0]          interval_id;
  logic signed [KeyW-1:0]  global_key;
  logic signed [KeyW-1:0]  local_key;
  modport source (output valid, kind, interval_id, global_key, local_key, input ready);
  modport sink   (input valid, kind, interval_id, global_key, local_key, output ready);
endinterface

interface dktq_out_if;
  import dktq_pkg::*;
  logic              valid;
  logic              ready;
  logic [IdW-1:0]    popped_id;
  logic              pop_ok;
  logic              any_empty;
  logic [FillW-1:0]  global_fill;
  logic [FillW-1:0]  local_fill;
  modport source (output valid, popped_id, pop_ok, any_empty, global_fill, local_fill,
                  input ready);
  modport sink   (input valid, popped_id, pop_ok, any_empty, global_fill, local_fill,
                  output ready);
endinterface

/* src/dktq_store.sv */
// ----------------------------------------------------------------------------
// dktq_store
// One sorted cell chain: slot 0 holds the maximum, entries below count valid.
// Supports insert with eviction of the minimum, pop of the head, delete by id
// lookup, link set at a slot and link clear by id lookup.
// ----------------------------------------------------------------------------
module dktq_store
  import dktq_pkg::*;
#(
  parameter int CAPACITY = DefCapacity,
  localparam int CntW = $clog2(CAPACITY + 1),
  localparam int PosW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clear,
  // insert (evicts minimum first when full)
  input  logic                   ins,
  input  logic [IdW-1:0]         ins_id,
  input  logic [KeyW-1:0]        ins_key,
  // pop head
  input  logic                   pop,
  // delete the first linked entry with del_id
  input  logic                   del,
  input  logic [IdW-1:0]         del_id,
  // clear link of first linked entry with unl_id
  input  logic                   unl,
  input  logic [IdW-1:0]         unl_id,
  // search the minimum evicted in this cycle as well
  input  logic                   unl_all,
  // set link on a slot
  input  logic                   setl,
  input  logic [PosW-1:0]        setl_pos,
  // status
  output logic [CntW-1:0]        count,
  output logic                   full,
  output logic [KeyW-1:0]        min_key,
  output logic [IdW-1:0]         min_id,
  output logic                   min_lnk,
  output logic [IdW-1:0]         head_id,
  output logic                   head_lnk,
  output logic [PosW-1:0]        ins_pos,
  output logic                   unl_at_min
);

  logic [IdW-1:0]   id_r  [CAPACITY];
  logic [KeyW-1:0]  key_r [CAPACITY];
  logic [CAPACITY-1:0] lnk_r;
  logic [CntW-1:0]  cnt_r, cnt_nxt;

  logic [CAPACITY-1:0] vld, ge, hit_del, hit_unl, first_del, first_unl, del_mask;
  logic [CAPACITY-1:0] lnk_src;
  logic [CntW-1:0]  base_cnt;
  logic [CntW-1:0]  unl_lim;
  logic             del_any;

  assign count = cnt_r;
  assign full  = (cnt_r == CntW'(CAPACITY));
  assign head_id  = id_r[0];
  assign head_lnk = lnk_r[0];
  assign min_key  = key_r[PosW'(cnt_r - CntW'(1))];
  assign min_id   = id_r[PosW'(cnt_r - CntW'(1))];
  assign min_lnk  = lnk_r[PosW'(cnt_r - CntW'(1))];

  // count after eviction of the minimum on a full insert
  assign base_cnt = (ins && full) ? cnt_r - CntW'(1) : cnt_r;
  assign unl_lim  = unl_all ? cnt_r : base_cnt;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      vld[i]     = (CntW'(i) < base_cnt);
      ge[i]      = vld[i] && (key_r[i] >= ins_key);
      hit_del[i] = (CntW'(i) < cnt_r) && lnk_r[i] && (id_r[i] == del_id);
      hit_unl[i] = (CntW'(i) < unl_lim) && lnk_r[i] && (id_r[i] == unl_id);
    end
    first_del = hit_del & (~hit_del + CAPACITY'(1));
    first_unl = hit_unl & (~hit_unl + CAPACITY'(1));
    // cells at or past the deleted slot shift up
    del_mask  = pop ? {CAPACITY{1'b1}} : (first_del | (first_del - CAPACITY'(1))) ^
                {CAPACITY{1'b1}} | first_del;
    del_any   = pop ? (cnt_r != '0) : (del && (hit_del != '0));
  end

  // link bits with the requested unlink applied, before any shift
  assign lnk_src    = lnk_r & ~(first_unl & {CAPACITY{unl}});
  assign unl_at_min = (cnt_r != '0) && first_unl[PosW'(cnt_r - CntW'(1))];

  // entries are sorted, so ge is a prefix; its popcount is the slot
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < CAPACITY; i++)
      if (ge[i]) ins_pos = PosW'(i + 1);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (clear)            cnt_nxt = '0;
    else if (ins)                  cnt_nxt = base_cnt + CntW'(1);
    else if ((pop || del) && del_any) cnt_nxt = cnt_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (ins) begin
        if (PosW'(i) == ins_pos && CntW'(i) <= base_cnt) begin
          id_r[i]  <= ins_id;
          key_r[i] <= ins_key;
          lnk_r[i] <= 1'b0;
        end else if (i > 0 && CntW'(i) > CntW'(ins_pos) && CntW'(i) <= base_cnt) begin
          id_r[i]  <= id_r[i-1];
          key_r[i] <= key_r[i-1];
          lnk_r[i] <= lnk_src[i-1];
        end else begin
          lnk_r[i] <= lnk_src[i];
        end
      end else if ((pop || del) && del_any && del_mask[i]) begin
        if (i + 1 < CAPACITY) begin
          id_r[i]  <= id_r[(i+1) % CAPACITY];
          key_r[i] <= key_r[(i+1) % CAPACITY];
          lnk_r[i] <= lnk_r[(i+1) % CAPACITY];
        end
      end else begin
        if (unl && first_unl[i]) lnk_r[i] <= 1'b0;
        if (setl && PosW'(i) == setl_pos) lnk_r[i] <= 1'b1;
      end
    end
  end

endmodule

/* src/dktq_ctrl.sv */
// ----------------------------------------------------------------------------
// dktq_ctrl
// Sequencer: accept a request, run the store update in two steps, present
// the result until taken.
// ----------------------------------------------------------------------------
module dktq_ctrl
  import dktq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output dktq_cmd_t   cmd
);

  dktq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* src/dktq_datapath.sv */
// ----------------------------------------------------------------------------
// dktq_datapath
// Request register, the two stores and the result register.
// ----------------------------------------------------------------------------
module dktq_datapath
  import dktq_pkg::*;
#(
  parameter int CAPACITY = DefCapacity,
  localparam int CntW = $clog2(CAPACITY + 1),
  localparam int PosW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dktq_cmd_t         cmd,
  input  logic [KindW-1:0]  kind,
  input  logic [IdW-1:0]    interval_id,
  input  logic [KeyW-1:0]   global_key,
  input  logic [KeyW-1:0]   local_key,
  output logic [IdW-1:0]    popped_id,
  output logic              pop_ok,
  output logic              any_empty,
  output logic [FillW-1:0]  global_fill,
  output logic [FillW-1:0]  local_fill
);

  logic [KindW-1:0] kind_r;
  logic [IdW-1:0]   id_r;
  logic [KeyW-1:0]  gk_r, lk_r;
  logic             glink_r, ppart_r;
  logic             pgl_r;
  logic [IdW-1:0]   pid_r;
  logic             pok_r;
  logic [PosW-1:0]  gpos_r, lpos_r;

  logic [CntW-1:0]  gcnt, lcnt;
  logic             gfull, lfull, gmin_l, lmin_l, ghead_l, lhead_l;
  logic [KeyW-1:0]  gmin_k, lmin_k;
  logic [IdW-1:0]   gmin_i, lmin_i, ghead_i, lhead_i;
  logic [PosW-1:0]  gpos, lpos;
  logic             is_push, bet, g_ok, l_ok, gins, lins, popg, popl;
  logic             g_del, l_del, g_setl, l_setl;
  logic             g_unl, l_unl, gunl_min, lunl_min;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      id_r   <= interval_id;
      gk_r   <= global_key ^ {1'b1, {(KeyW-1){1'b0}}};
      lk_r   <= local_key ^ {1'b1, {(KeyW-1){1'b0}}};
    end
  end

  assign is_push = (kind_r == KIND_PUSH) || (kind_r == KIND_PUSH_BET);
  assign bet     = (kind_r == KIND_PUSH_BET);
  assign g_ok = (gcnt == '0) || (bet ? (gk_r >= gmin_k) : (!gfull || gk_r > gmin_k));
  assign l_ok = (lcnt == '0) || (bet ? (lk_r >= lmin_k) : (!lfull || lk_r > lmin_k));
  assign gins = cmd.exec && is_push && g_ok;
  assign lins = cmd.exec && is_push && l_ok;
  assign popg = cmd.exec && (kind_r == KIND_POP_G);
  assign popl = cmd.exec && (kind_r == KIND_POP_L);

  // global eviction unlinks in local first; a local minimum unlinked that way
  // no longer unlinks anything in global when it is evicted
  assign l_unl = gins && gfull && gmin_l && !gunl_min;
  assign g_unl = lins && lfull && lmin_l && !(l_unl && lunl_min);

  // second step: partner delete after a pop, or link both new entries
  assign g_del  = cmd.fix && ppart_r && !pgl_r;
  assign l_del  = cmd.fix && ppart_r && pgl_r;
  assign g_setl = cmd.fix && glink_r;
  assign l_setl = cmd.fix && glink_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pok_r <= 1'b0;
      pid_r <= '0;
    end
    if (cmd.exec) begin
      glink_r <= gins && lins;
      gpos_r  <= gpos;
      lpos_r  <= lpos;
      pgl_r   <= (kind_r == KIND_POP_G);
      ppart_r <= 1'b0;
      if (popg && gcnt != '0) begin
        pok_r <= 1'b1; pid_r <= ghead_i; ppart_r <= ghead_l;
      end
      if (popl && lcnt != '0) begin
        pok_r <= 1'b1; pid_r <= lhead_i; ppart_r <= lhead_l;
      end
    end
    if (cmd.fix) begin
      glink_r <= 1'b0;
      ppart_r <= 1'b0;
    end
  end

  dktq_store #(.CAPACITY(CAPACITY)) u_gstore (
    .clk, .rst_n,
    .clear   (cmd.exec && kind_r == KIND_CLEAR),
    .ins     (gins), .ins_id(id_r), .ins_key(gk_r),
    .pop     (popg),
    .del     (g_del), .del_id(pid_r),
    .unl     (g_unl), .unl_id(lmin_i), .unl_all(1'b0),
    .setl    (g_setl), .setl_pos(gpos_r),
    .count   (gcnt), .full(gfull), .min_key(gmin_k), .min_id(gmin_i),
    .min_lnk (gmin_l), .head_id(ghead_i), .head_lnk(ghead_l), .ins_pos(gpos),
    .unl_at_min(gunl_min)
  );

  dktq_store #(.CAPACITY(CAPACITY)) u_lstore (
    .clk, .rst_n,
    .clear   (cmd.exec && kind_r == KIND_CLEAR),
    .ins     (lins), .ins_id(id_r), .ins_key(lk_r),
    .pop     (popl),
    .del     (l_del), .del_id(pid_r),
    .unl     (l_unl), .unl_id(gmin_i), .unl_all(1'b1),
    .setl    (l_setl), .setl_pos(lpos_r),
    .count   (lcnt), .full(lfull), .min_key(lmin_k), .min_id(lmin_i),
    .min_lnk (lmin_l), .head_id(lhead_i), .head_lnk(lhead_l), .ins_pos(lpos),
    .unl_at_min(lunl_min)
  );

  assign popped_id   = pid_r;
  assign pop_ok      = pok_r;
  assign any_empty   = (gcnt == '0) || (lcnt == '0);
  assign global_fill = FillW'(gcnt);
  assign local_fill  = FillW'(lcnt);

endmodule

/* src/dual_key_bounded_topk_queue.sv */
// ----------------------------------------------------------------------------
// dual_key_bounded_topk_queue
// Two bounded sorted stores keeping the best entries by global and local key.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel: one request (kind, interval_id, global_key, local_key).
//   out channel: one result per request (popped id, pop flag, fills).
//   A request is taken when the block is idle. It first does
//   insert/evict/pop in the sorted cell chains, then links or deletes the
//   partner, and the result is presented after both steps.
//   The next request is taken the cycle after the result is delivered;
//   no new request is taken while one is in flight, as the two-step
//   cell chain update and the single result register serve one at a time.
//   Reset empties both stores at once; no clearing pass is needed.
//   While the receiver stalls the result holds and no request is taken.
// ----------------------------------------------------------------------------
module dual_key_bounded_topk_queue
  import dktq_pkg::*;
#(
  parameter int CAPACITY = DefCapacity
) (
  input  logic  clk,
  input  logic  rst_n,
  dktq_in_if.sink    in_ch,
  dktq_out_if.source out_ch
);

  `include "assert_macros.svh"

  dktq_cmd_t cmd;

  dktq_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd
  );

  dktq_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst_n, .cmd,
    .kind        (in_ch.kind),
    .interval_id (in_ch.interval_id),
    .global_key  (in_ch.global_key),
    .local_key   (in_ch.local_key),
    .popped_id   (out_ch.popped_id),
    .pop_ok      (out_ch.pop_ok),
    .any_empty   (out_ch.any_empty),
    .global_fill (out_ch.global_fill),
    .local_fill  (out_ch.local_fill)
  );

  `ASSERT_IMPL(a_no_overlap, clk, rst_n, in_ch.ready, !out_ch.valid,
    "request taken while result pending")
  `ASSERT_IMPL(a_popid_zero, clk, rst_n, out_ch.valid && !out_ch.pop_ok,
    out_ch.popped_id == '0, "popped id without pop")
  `ASSERT_NEXT(a_load_exec, clk, rst_n, cmd.load, cmd.exec, "exec must follow load")

endmodule

/* verif/dual_key_bounded_topk_queue_test.sv */
// ----------------------------------------------------------------------------
// dual_key_bounded_topk_queue_test
// Drives push, push-if-better, pop, clear and unused-kind requests into the dual-key
// top-k queue, predicts every result with a behavioral copy of both stores
// and checks all fields of each result, with random gaps on both channels.
// ----------------------------------------------------------------------------
module dual_key_bounded_topk_queue_test;
  import dktq_pkg::*;

  localparam int Cap = DefCapacity;
  localparam int NumRandom = 1600;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic [KindW-1:0]       kind;
    logic [IdW-1:0]         interval_id;
    logic signed [KeyW-1:0] global_key;
    logic signed [KeyW-1:0] local_key;
  } request_t;

  typedef struct packed {
    logic [IdW-1:0]   popped_id;
    logic             pop_ok;
    logic             any_empty;
    logic [FillW-1:0] global_fill;
    logic [FillW-1:0] local_fill;
  } result_t;

  // store 0 is ordered by global key, store 1 by local key
  typedef struct {
    logic [IdW-1:0]         ids[Cap];
    logic signed [KeyW-1:0] keys[Cap];
    bit                     linked[Cap];
    int                     count;
  } store_t;

  logic clk;
  logic rst_n;

  dktq_in_if  in_ch ();
  dktq_out_if out_ch ();

  dual_key_bounded_topk_queue DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  store_t    stores[2];
  request_t  pending_requests[$];
  result_t   expected_results[$];
  int        mismatches;
  int        results_seen;
  int        pops_ok;
  int        evictions;
  int        in_gap;
  int        out_gap;
  bit        drain_hold;
  longint    cycle_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int find_linked(int s, logic [IdW-1:0] id);
    for (int p = 0; p < stores[s].count; p++)
      if (stores[s].ids[p] == id && stores[s].linked[p]) return p;
    return Cap;
  endfunction

  function automatic void remove_slot(int s, int pos);
    if (pos >= stores[s].count) return;
    for (int p = pos; p + 1 < stores[s].count; p++) begin
      stores[s].ids[p]    = stores[s].ids[p + 1];
      stores[s].keys[p]   = stores[s].keys[p + 1];
      stores[s].linked[p] = stores[s].linked[p + 1];
    end
    stores[s].count--;
  endfunction

  // returns slot of the new entry, or Cap when refused
  function automatic int offer_entry(int s, logic [IdW-1:0] id,
                                     logic signed [KeyW-1:0] key, bit if_better);
    int pos;
    int q;
    int n;
    n = stores[s].count;
    if (n > 0) begin
      if (if_better) begin
        if (key < stores[s].keys[n - 1]) return Cap;
      end else if (n >= Cap && !(key > stores[s].keys[n - 1])) begin
        return Cap;
      end
      if (n >= Cap) begin
        // evict the minimum and unlink its partner
        evictions++;
        if (stores[s].linked[n - 1]) begin
          q = find_linked(1 - s, stores[s].ids[n - 1]);
          if (q < Cap) stores[1 - s].linked[q] = 1'b0;
        end
        remove_slot(s, n - 1);
      end
    end
    n = stores[s].count;
    pos = 0;
    while (pos < n && stores[s].keys[pos] >= key) pos++;
    for (int p = n; p > pos; p--) begin
      stores[s].ids[p]    = stores[s].ids[p - 1];
      stores[s].keys[p]   = stores[s].keys[p - 1];
      stores[s].linked[p] = stores[s].linked[p - 1];
    end
    stores[s].ids[pos]    = id;
    stores[s].keys[pos]   = key;
    stores[s].linked[pos] = 1'b0;
    stores[s].count++;
    return pos;
  endfunction

  function automatic result_t queue_update(request_t req);
    result_t r;
    int gp;
    int lp;
    int s;
    bit lk;
    r = '0;
    case (req.kind)
      KIND_PUSH, KIND_PUSH_BET: begin
        gp = offer_entry(0, req.interval_id, req.global_key, req.kind == KIND_PUSH_BET);
        lp = offer_entry(1, req.interval_id, req.local_key, req.kind == KIND_PUSH_BET);
        if (gp < Cap && lp < Cap) begin
          stores[0].linked[gp] = 1'b1;
          stores[1].linked[lp] = 1'b1;
        end
      end
      KIND_POP_G, KIND_POP_L: begin
        s = (req.kind == KIND_POP_G) ? 0 : 1;
        if (stores[s].count > 0) begin
          r.popped_id = stores[s].ids[0];
          r.pop_ok    = 1'b1;
          lk = stores[s].linked[0];
          remove_slot(s, 0);
          if (lk) remove_slot(1 - s, find_linked(1 - s, r.popped_id));
          pops_ok++;
        end
      end
      KIND_CLEAR: begin
        stores[0].count = 0;
        stores[1].count = 0;
      end
      default: ;
    endcase
    r.any_empty   = (stores[0].count == 0) || (stores[1].count == 0);
    r.global_fill = stores[0].count[FillW-1:0];
    r.local_fill  = stores[1].count[FillW-1:0];
    return r;
  endfunction

  function automatic logic signed [KeyW-1:0] rand_key(bit narrow);
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      default: return narrow ? $signed(32'($urandom_range(0, 40)) - 20) : $signed($urandom);
    endcase
  endfunction

  function automatic request_t make_req(logic [KindW-1:0] kind, logic [IdW-1:0] id,
                                        logic signed [KeyW-1:0] gk,
                                        logic signed [KeyW-1:0] lk);
    request_t r;
    r.kind = kind;
    r.interval_id = id;
    r.global_key = gk;
    r.local_key = lk;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap <= $urandom_range(0, 9);
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the request
    end else begin
      if (in_ch.valid) begin
        expected_results.push_back(queue_update(pending_requests.pop_front()));
        in_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
      end
      if (pending_requests.size() > 0 && !drain_hold &&
          (in_ch.valid ? (in_gap == 0 || $urandom_range(0, 3) == 0) : in_gap == 0)) begin
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= pending_requests[0].kind;
        in_ch.interval_id <= pending_requests[0].interval_id;
        in_ch.global_key  <= pending_requests[0].global_key;
        in_ch.local_key   <= pending_requests[0].local_key;
      end else begin
        in_ch.valid <= 1'b0;
        if (!in_ch.valid && in_gap > 0) in_gap <= in_gap - 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.popped_id, out_ch.pop_ok, out_ch.any_empty,
               out_ch.global_fill, out_ch.local_fill};
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: expected %p, got %p", results_seen, want, got);
          end
        end
        out_gap <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [IdW-1:0] next_id;
    int burst;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_PUSH;
    in_ch.interval_id = '0;
    in_ch.global_key = '0;
    in_ch.local_key = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    pops_ok = 0;
    evictions = 0;
    drain_hold = 1'b0;
    cycle_count = 0;
    stores[0].count = 0;
    stores[1].count = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pops, extremes, equal keys, unused kinds, clear
    pending_requests.push_back(make_req(KIND_POP_G, 16'h0, 0, 0));
    pending_requests.push_back(make_req(KIND_POP_L, 16'h0, 0, 0));
    pending_requests.push_back(make_req(KIND_PUSH_BET, 16'hffff, 32'sh7fff_ffff,
                                        32'sh8000_0000));
    pending_requests.push_back(make_req(KIND_PUSH, 16'h0001, 32'sh8000_0000,
                                        32'sh7fff_ffff));
    pending_requests.push_back(make_req(KIND_PUSH, 16'h0002, 5, 5));
    pending_requests.push_back(make_req(KIND_PUSH, 16'h0003, 5, 5));
    pending_requests.push_back(make_req(KIND_PUSH_BET, 16'h0004, -1, 32'sh8000_0000));
    pending_requests.push_back(make_req(KIND_PUSH_BET, 16'h0005, 32'sh8000_0000, -3));
    pending_requests.push_back(make_req(3'd5, 16'hffff, -1, -1));
    pending_requests.push_back(make_req(3'd6, 16'h1234, 0, 0));
    pending_requests.push_back(make_req(3'd7, 16'h0, 0, 0));
    pending_requests.push_back(make_req(KIND_POP_G, 16'h0, 0, 0));
    pending_requests.push_back(make_req(KIND_POP_L, 16'h0, 0, 0));
    pending_requests.push_back(make_req(KIND_POP_L, 16'h0, 0, 0));
    pending_requests.push_back(make_req(KIND_CLEAR, 16'h0, 0, 0));
    pending_requests.push_back(make_req(KIND_POP_G, 16'h0, 0, 0));
    // fill past capacity to force evictions, including equal-to-min keys
    for (int i = 0; i < Cap + 8; i++)
      pending_requests.push_back(make_req(KIND_PUSH, 16'(16'h100 + i),
                                          $signed(32'(i % 10)), $signed(32'(9 - i % 10))));
    pending_requests.push_back(make_req(KIND_PUSH_BET, 16'h0200, 0, 0));
    pending_requests.push_back(make_req(KIND_PUSH_BET, 16'h0201, -5, 100));

    wait (pending_requests.size() == 0);
    // let everything drain before the random part
    drain_hold = 1'b1;
    wait (expected_results.size() == 0);
    @(posedge clk);
    drain_hold = 1'b0;

    next_id = 16'h1000;
    for (int n = 0; n < NumRandom; n += burst) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) begin
        request_t r;
        int pick;
        bit narrow;
        pick = $urandom_range(0, 99);
        narrow = ($urandom_range(0, 1) == 1);
        r.interval_id = ($urandom_range(0, 19) == 0) ? 16'($urandom) : next_id;
        next_id++;
        r.global_key = rand_key(narrow);
        r.local_key = rand_key(narrow);
        if (pick < 40)      r.kind = KIND_PUSH;
        else if (pick < 60) r.kind = KIND_PUSH_BET;
        else if (pick < 78) r.kind = KIND_POP_G;
        else if (pick < 96) r.kind = KIND_POP_L;
        else if (pick < 98) r.kind = KIND_CLEAR;
        else                r.kind = 3'($urandom_range(5, 7));
        pending_requests.push_back(r);
      end
      if ($urandom_range(0, 2) == 0) begin
        // long push run to reach full stores
        for (int b = 0; b < 80; b++)
          pending_requests.push_back(make_req(KIND_PUSH, next_id++, rand_key(1'b1),
                                              rand_key(1'b0)));
        burst += 80;
      end
    end

    wait (pending_requests.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    $display("ran %0d results, %0d successful pops, %0d evictions predicted",
             results_seen, pops_ok, evictions);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
